@@ sv/ezr_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the 2^(2^-(j+1)) root table for the zoom ramp integrator
// no dependencies

package ezr_pkg;

  // field widths
  localparam int unsigned LEVEL_W   = 24;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned SF_W      = 17;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 24;

  localparam int unsigned EXP_TABLE_BITS  = 8;
  localparam int unsigned LEVEL_FRAC_BITS = 16;

  // factor f is Q1.30
  localparam int unsigned F_FRAC = 30;
  localparam int unsigned F_W    = F_FRAC + 1;

  // shared serial multiplier
  localparam int unsigned MUL_W     = 31;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_W);

  // serial divider
  localparam int unsigned REM_W       = F_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(LEVEL_W);
  localparam int unsigned DIV_PRESHIFT = F_FRAC - LEVEL_W;

  // working level with one overflow bit, integer exponent
  localparam int unsigned V_W = LEVEL_W + 1;
  localparam int unsigned P_W = 6;
  localparam int unsigned J_W = $clog2(EXP_TABLE_BITS);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET =
    LEVEL_W'((64'd1 << LEVEL_FRAC_BITS) & 64'hFF_FFFF);
  localparam logic [SF_W-1:0]    SF_ONE      = SF_W'(65536);
  localparam logic [F_W-1:0]     F_ONE       = F_W'(64'd1 << F_FRAC);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_SET     = 2'd1,
    MODE_RESTART = 2'd2
  } ezr_mode_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE = 2'd0,
    DIR_IN   = 2'd1,
    DIR_OUT  = 2'd2
  } ezr_dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEVEL      = 3'd0,
    CFG_MAX_LEVEL      = 3'd1,
    CFG_IN_SPEED       = 3'd2,
    CFG_OUT_SPEED      = 3'd3,
    CFG_SMOOTH_ENABLE  = 3'd4,
    CFG_START_FRACTION = 3'd5,
    CFG_RAMP_RATE      = 3'd6
  } ezr_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RAMP_T,
    ST_RAMP_A,
    ST_RAMP_S,
    ST_EXP,
    ST_ROOT_SCAN,
    ST_ROOT_MUL,
    ST_LEVEL_MUL,
    ST_LEVEL_DIV,
    ST_SHIFT,
    ST_FINISH,
    ST_DONE
  } ezr_state_e;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               zoom_in_held;
    logic               zoom_out_held;
    logic [DT_W-1:0]    dt;
    logic [LEVEL_W-1:0] new_level;
  } ezr_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [DIR_W-1:0]   direction;
  } ezr_out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
    logic [SPEED_W-1:0] in_speed;
    logic [SPEED_W-1:0] out_speed;
    logic               smooth_enable;
    logic [SF_W-1:0]    start_fraction;
    logic [LEVEL_W-1:0] ramp_rate;
  } ezr_cfg_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } ezr_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } ezr_mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] num;
    logic [F_W-1:0]     den;
  } ezr_div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quo;
  } ezr_div_rsp_t;

  typedef logic [EXP_TABLE_BITS-1:0][F_W-1:0] ezr_root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bitv;
    int          i;
    res = '0;
    rem = v;
    for (i = 31; i >= 0; i--) begin
      bitv = 64'd1 << (2 * i);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // entry j holds 2^(2^-(j+1)) in Q1.30, each root taken from the one before
  function automatic ezr_root_tab_t build_roots();
    ezr_root_tab_t tab;
    logic [63:0]   r;
    int            j;
    tab = '0;
    r   = 64'd1 << (F_FRAC + 1);
    for (j = 0; j < EXP_TABLE_BITS; j++) begin
      r      = isqrt64(r << F_FRAC);
      tab[j] = F_W'(r);
    end
    return tab;
  endfunction

  localparam ezr_root_tab_t EXP_ROOT = build_roots();

endpackage

@@ sv/ezr_serial_mul.sv @@
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle, product held from the done strobe on
// depends on ezr_pkg

module ezr_serial_mul
  import ezr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ezr_mul_req_t req_i,
  output ezr_mul_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_W-1:0]     a_q, a_d;
  logic [MUL_W-1:0]     hi_q, hi_d;
  logic [MUL_W-1:0]     lo_q, lo_d;
  logic [MUL_W:0]       sum;

  always_comb begin
    sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.a;
      hi_d   = '0;
      lo_d   = req_i.b;
    end else if (busy_q) begin
      hi_d  = sum[MUL_W:1];
      lo_d  = {sum[0], lo_q[MUL_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MUL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q, lo_q};

endmodule

@@ sv/ezr_serial_div.sv @@
`timescale 1ns / 1ps
// restoring divider for (level << 30) / f, one quotient bit per cycle
// depends on ezr_pkg

module ezr_serial_div
  import ezr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ezr_div_req_t req_i,
  output ezr_div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [F_W-1:0]       den_q, den_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [LEVEL_W-1:0]   quo_q, quo_d;
  logic [REM_W-1:0]     rem_sh;
  logic                 fits;

  always_comb begin
    rem_sh = {rem_q[REM_W-2:0], 1'b0};
    fits   = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = req_i.den;
      // low dividend bits are all zero, so the top part seeds the remainder
      rem_d  = REM_W'(req_i.num) << DIV_PRESHIFT;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[LEVEL_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(LEVEL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

@@ sv/ezr_seq.sv @@
`timescale 1ns / 1ps
// zoom state and sequencer: speed ramp, exponent, root chain, level update
// depends on ezr_pkg, ezr_serial_mul, ezr_serial_div

module ezr_seq
  import ezr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ezr_cfg_t cfg_i,
  input  logic     req_valid_i,
  output logic     req_stall_o,
  input  ezr_in_t  req_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output ezr_out_t res_o
);

  ezr_state_e                state_q, state_d;
  logic [LEVEL_W-1:0]        level_q, level_d;
  logic [LEVEL_W-1:0]        held_q, held_d;
  ezr_dir_e                  dir_q, dir_d;
  logic [DT_W-1:0]           dt_q, dt_d;
  logic [P_W-1:0]            p_q, p_d;
  logic [EXP_TABLE_BITS-1:0] frac_q, frac_d;
  logic [J_W-1:0]            j_q, j_d;
  logic [F_W-1:0]            f_q, f_d;
  logic [V_W-1:0]            v_q, v_d;

  ezr_mul_req_t mul_req;
  ezr_mul_rsp_t mul_rsp;
  ezr_div_req_t div_req;
  ezr_div_rsp_t div_rsp;

  ezr_dir_e           tick_dir;
  logic [LEVEL_W:0]   held_sum;
  logic [LEVEL_W-1:0] held_next;
  logic               smooth_on;
  logic [SPEED_W-1:0] base_speed;
  logic [SF_W-1:0]    ramp_t;
  logic [SF_W-1:0]    ramp_a;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [V_W-1:0] v,
                                                     input logic [LEVEL_W-1:0] lo,
                                                     input logic [LEVEL_W-1:0] hi);
    logic [V_W-1:0] r;
    r = (v < {1'b0, lo}) ? {1'b0, lo} : v;
    r = (r > {1'b0, hi}) ? {1'b0, hi} : r;
    return LEVEL_W'(r);
  endfunction

  function automatic logic [MUL_W-1:0] times5(input logic [SPEED_W-1:0] s);
    return MUL_W'({s, 2'b00}) + MUL_W'(s);
  endfunction

  ezr_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ezr_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (req_i.zoom_in_held == req_i.zoom_out_held) begin
      tick_dir = DIR_NONE;
    end else if (req_i.zoom_in_held) begin
      tick_dir = DIR_IN;
    end else begin
      tick_dir = DIR_OUT;
    end
    held_sum = {1'b0, held_q} + (LEVEL_W + 1)'(req_i.dt);
    if (tick_dir != DIR_IN) begin
      held_next = '0;
    end else if (req_i.dt == '0) begin
      held_next = held_q;
    end else begin
      held_next = held_sum[LEVEL_W] ? LEVEL_MAX : held_sum[LEVEL_W-1:0];
    end
    smooth_on  = cfg_i.smooth_enable && (cfg_i.start_fraction < SF_ONE);
    base_speed = (tick_dir == DIR_IN) ? cfg_i.in_speed : cfg_i.out_speed;
    ramp_t     = (mul_rsp.prod[47:16] > 32'(SF_ONE)) ? SF_ONE : mul_rsp.prod[32:16];
    ramp_a     = cfg_i.start_fraction + mul_rsp.prod[32:16];
  end

  always_comb begin
    state_d = state_q;
    level_d = level_q;
    held_d  = held_q;
    dir_d   = dir_q;
    dt_d    = dt_q;
    p_d     = p_q;
    frac_d  = frac_q;
    j_d     = j_q;
    f_d     = f_q;
    v_d     = v_q;
    mul_req = '0;
    div_req = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          dt_d    = req_i.dt;
          state_d = ST_DONE;
          case (req_i.mode)
            MODE_TICK: begin
              dir_d  = tick_dir;
              held_d = held_next;
              if (tick_dir != DIR_NONE && req_i.dt != '0) begin
                mul_req.start = 1'b1;
                if (tick_dir == DIR_IN && smooth_on) begin
                  if (cfg_i.ramp_rate == '0) begin
                    mul_req.a = MUL_W'(SF_ONE - cfg_i.start_fraction);
                    mul_req.b = MUL_W'(SF_ONE);
                    state_d   = ST_RAMP_A;
                  end else begin
                    mul_req.a = MUL_W'(held_next);
                    mul_req.b = MUL_W'(cfg_i.ramp_rate);
                    state_d   = ST_RAMP_T;
                  end
                end else begin
                  mul_req.a = times5(base_speed);
                  mul_req.b = MUL_W'(req_i.dt);
                  state_d   = ST_EXP;
                end
              end
            end
            MODE_SET: begin
              level_d = clamp_level(V_W'(req_i.new_level), cfg_i.min_level, cfg_i.max_level);
            end
            MODE_RESTART: begin
              level_d = cfg_i.min_level;
              held_d  = '0;
              dir_d   = DIR_NONE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RAMP_T: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_W'(SF_ONE - cfg_i.start_fraction);
          mul_req.b     = MUL_W'(ramp_t);
          state_d       = ST_RAMP_A;
        end
      end
      ST_RAMP_A: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_W'(cfg_i.in_speed);
          mul_req.b     = MUL_W'(ramp_a);
          state_d       = ST_RAMP_S;
        end
      end
      ST_RAMP_S: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = times5(mul_rsp.prod[31:16]);
          mul_req.b     = MUL_W'(dt_q);
          state_d       = ST_EXP;
        end
      end
      ST_EXP: begin
        if (mul_rsp.done) begin
          // e = prod >> 1 in Q.28
          p_d     = mul_rsp.prod[34:29];
          frac_d  = mul_rsp.prod[28 -: EXP_TABLE_BITS];
          f_d     = F_ONE;
          j_d     = '0;
          state_d = ST_ROOT_SCAN;
        end
      end
      ST_ROOT_SCAN: begin
        if (frac_q == '0) begin
          if (dir_q == DIR_IN) begin
            mul_req.start = 1'b1;
            mul_req.a     = MUL_W'(f_q);
            mul_req.b     = MUL_W'(level_q);
            state_d       = ST_LEVEL_MUL;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = level_q;
            div_req.den   = f_q;
            state_d       = ST_LEVEL_DIV;
          end
        end else if (frac_q[EXP_TABLE_BITS-1]) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_W'(f_q);
          mul_req.b     = MUL_W'(EXP_ROOT[j_q]);
          state_d       = ST_ROOT_MUL;
        end else begin
          frac_d = {frac_q[EXP_TABLE_BITS-2:0], 1'b0};
          j_d    = j_q + 1'b1;
        end
      end
      ST_ROOT_MUL: begin
        if (mul_rsp.done) begin
          f_d     = mul_rsp.prod[F_FRAC +: F_W];
          frac_d  = {frac_q[EXP_TABLE_BITS-2:0], 1'b0};
          j_d     = j_q + 1'b1;
          state_d = ST_ROOT_SCAN;
        end
      end
      ST_LEVEL_MUL: begin
        if (mul_rsp.done) begin
          v_d     = mul_rsp.prod[F_FRAC +: V_W];
          state_d = ST_SHIFT;
        end
      end
      ST_LEVEL_DIV: begin
        if (div_rsp.done) begin
          v_d     = V_W'(div_rsp.quo);
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // integer part of the exponent, one bit position per cycle
        if (dir_q == DIR_IN && v_q[V_W-1]) begin
          v_d     = V_W'(LEVEL_MAX);
          state_d = ST_FINISH;
        end else if (p_q == '0 || v_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          v_d = (dir_q == DIR_IN) ? {v_q[V_W-2:0], 1'b0} : {1'b0, v_q[V_W-1:1]};
          p_d = p_q - 1'b1;
        end
      end
      ST_FINISH: begin
        level_d = clamp_level(v_q, cfg_i.min_level, cfg_i.max_level);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      level_q <= LEVEL_RESET;
      held_q  <= '0;
      dir_q   <= DIR_NONE;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      held_q  <= held_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    p_q    <= p_d;
    frac_q <= frac_d;
    j_q    <= j_d;
    f_q    <= f_d;
    v_q    <= v_d;
  end

  assign req_stall_o     = (state_q != ST_IDLE);
  assign res_valid_o     = (state_q == ST_DONE);
  assign res_o.level     = level_q;
  assign res_o.direction = dir_q;

endmodule

@@ sv/exponential_zoom_ramp_integrator_top.sv @@
`timescale 1ns / 1ps
// top level of the exponential zoom ramp integrator: config registers, output register
// depends on ezr_pkg, ezr_seq
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (ezr_in_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (ezr_out_t)
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one request in flight; set level, restart, unused mode and a still tick go straight
// to the done state. a moving tick runs no, two or three ramp products, the exponent
// product, one product per set fraction bit (clear bits are only scanned) and a level
// product or divide through the bit-serial units, then shifts the level by the integer
// exponent, one bit position at a time until zero or saturation, and clamps the result.
// reset loads the register defaults and a level of 1.0. the output register holds a
// result under out_stall_i while the next request is already accepted.

module exponential_zoom_ramp_integrator_top
  import ezr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ezr_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ezr_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  ezr_cfg_t cfg_q;
  logic     out_valid_q;
  ezr_out_t out_q;
  logic     seq_res_valid;
  logic     seq_res_ready;
  ezr_out_t seq_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_level      <= LEVEL_W'(65536);
      cfg_q.max_level      <= LEVEL_W'(524288);
      cfg_q.in_speed       <= SPEED_W'(4096);
      cfg_q.out_speed      <= SPEED_W'(4096);
      cfg_q.smooth_enable  <= 1'b0;
      cfg_q.start_fraction <= SF_ONE;
      cfg_q.ramp_rate      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_LEVEL:      cfg_q.min_level      <= cfg_data_i[LEVEL_W-1:0];
        CFG_MAX_LEVEL:      cfg_q.max_level      <= cfg_data_i[LEVEL_W-1:0];
        CFG_IN_SPEED:       cfg_q.in_speed       <= cfg_data_i[SPEED_W-1:0];
        CFG_OUT_SPEED:      cfg_q.out_speed      <= cfg_data_i[SPEED_W-1:0];
        CFG_SMOOTH_ENABLE:  cfg_q.smooth_enable  <= cfg_data_i[0];
        CFG_START_FRACTION: cfg_q.start_fraction <= cfg_data_i[SF_W-1:0];
        CFG_RAMP_RATE:      cfg_q.ramp_rate      <= cfg_data_i[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ezr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_valid_i (in_valid_i),
    .req_stall_o (in_stall_o),
    .req_i       (in_data_i),
    .res_valid_o (seq_res_valid),
    .res_ready_i (seq_res_ready),
    .res_o       (seq_res)
  );

  assign seq_res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_res_valid && seq_res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res_valid && seq_res_ready) begin
      out_q <= seq_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // an accepted request always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer did not leave idle after a request");

  // no new request is taken while a result waits in the sequencer
  a_result_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_res_valid |-> in_stall_o)
    else $error("request accepted while a result is pending");

  // a pending result is neither dropped nor altered while the output register is full
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_res_valid && !seq_res_ready |=> seq_res_valid && $stable(seq_res))
    else $error("pending result lost or changed");
`endif

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// testbench for exponential_zoom_ramp_integrator_top: directed, random and backpressure traffic
// results are checked against an in-bench zoom predictor; depends on ezr_pkg and the rtl

module tb;
  import ezr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [63:0]       SAT24       = 64'hFF_FFFF;
  localparam int unsigned       HOLD_CYCLES = 1500;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  ezr_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  ezr_out_t             out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  exponential_zoom_ramp_integrator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and register copy
  ezr_cfg_t           zoom_cfg;
  logic [LEVEL_W-1:0] level_q;
  logic [LEVEL_W-1:0] held_time;
  ezr_dir_e           cur_dir;

  ezr_out_t    expected_q[$];
  int unsigned fail_count = 0;
  int unsigned requests_sent = 0;
  int unsigned results_checked = 0;
  int unsigned configs_loaded = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycle = 0;
  int unsigned hold_until = 0;

  ezr_dir_e    run_dir = DIR_NONE;
  int unsigned run_left = 0;

  function automatic logic [LEVEL_W-1:0] clamp_to_limits(input logic [63:0] v);
    if (v < 64'(zoom_cfg.min_level)) v = 64'(zoom_cfg.min_level);
    if (v > 64'(zoom_cfg.max_level)) v = 64'(zoom_cfg.max_level);
    return v[LEVEL_W-1:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    int          b;
    root = '0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // 2^frac in Q1.30 from the top table bits of a Q.28 fraction
  function automatic logic [63:0] frac_pow2(input logic [27:0] frac);
    logic [63:0] f;
    logic [63:0] r;
    int          j;
    f = 64'd1 << 30;
    r = 64'd1 << 31;
    for (j = 1; j <= EXP_TABLE_BITS; j++) begin
      r = floor_sqrt(r << 30);
      if (frac[28-j]) f = (f * r) >> 30;
    end
    return f;
  endfunction

  function automatic ezr_out_t zoom_step(input ezr_in_t req);
    ezr_out_t    res;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] f;
    logic [63:0] v;
    logic [63:0] h;
    int unsigned p;
    ezr_dir_e    dir;
    case (req.mode)
      MODE_TICK: begin
        if (req.zoom_in_held == req.zoom_out_held) dir = DIR_NONE;
        else if (req.zoom_in_held) dir = DIR_IN;
        else dir = DIR_OUT;
        cur_dir = dir;
        if (dir == DIR_IN && req.dt != '0) begin
          h = 64'(held_time) + 64'(req.dt);
          held_time = (h > SAT24) ? LEVEL_MAX : h[LEVEL_W-1:0];
        end else if (dir != DIR_IN) begin
          held_time = '0;
        end
        if (dir != DIR_NONE && req.dt != '0) begin
          if (dir == DIR_IN) begin
            s = 64'(zoom_cfg.in_speed);
            if (zoom_cfg.smooth_enable && zoom_cfg.start_fraction < SF_ONE) begin
              t = 64'd65536;
              if (zoom_cfg.ramp_rate != '0) begin
                t = (64'(held_time) * 64'(zoom_cfg.ramp_rate)) >> 16;
                if (t > 64'd65536) t = 64'd65536;
              end
              a = 64'(zoom_cfg.start_fraction) +
                  (((64'd65536 - 64'(zoom_cfg.start_fraction)) * t) >> 16);
              s = (64'(zoom_cfg.in_speed) * a) >> 16;
            end
          end else begin
            s = 64'(zoom_cfg.out_speed);
          end
          e = (64'(req.dt) * s * 64'd5) >> 1;
          p = 32'(e >> 28);
          f = frac_pow2(e[27:0]);
          if (dir == DIR_IN) begin
            v = (64'(level_q) * f) >> 30;
            if (v != '0 && (p >= 24 || (v << p) > SAT24)) v = SAT24;
            else if (v != '0) v = v << p;
          end else begin
            v = (64'(level_q) << 30) / f;
            v = (p >= 63) ? 64'd0 : (v >> p);
            if (v > SAT24) v = SAT24;
          end
          level_q = clamp_to_limits(v);
        end
      end
      MODE_SET: level_q = clamp_to_limits(64'(req.new_level));
      MODE_RESTART: begin
        level_q   = zoom_cfg.min_level;
        held_time = '0;
        cur_dir   = DIR_NONE;
      end
      default: ;
    endcase
    res.level     = level_q;
    res.direction = cur_dir;
    return res;
  endfunction

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i) begin
    out_stall_i <= (stall_cycle < hold_until) || ($urandom_range(99) < recv_idle_pct);
    stall_cycle <= stall_cycle + 1;
  end

  always @(posedge clk_i) begin : check_result
    ezr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: level %h direction %0d",
               out_data_o.level, out_data_o.direction);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (out_data_o.level !== want.level) begin
          $error("level mismatch: expected %h actual %h", want.level, out_data_o.level);
          fail_count++;
        end
        if (out_data_o.direction !== want.direction) begin
          $error("direction mismatch: expected %0d actual %0d",
                 want.direction, out_data_o.direction);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(input ezr_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(zoom_step(req));
    requests_sent++;
  endtask

  task automatic send_op(input logic [MODE_W-1:0] mode, input logic zin, input logic zout,
                         input logic [DT_W-1:0] dt, input logic [LEVEL_W-1:0] lvl);
    ezr_in_t req;
    req.mode          = mode;
    req.zoom_in_held  = zin;
    req.zoom_out_held = zout;
    req.dt            = dt;
    req.new_level     = lvl;
    send_request(req);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input ezr_cfg_idx_e idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_LEVEL:      zoom_cfg.min_level      = val;
      CFG_MAX_LEVEL:      zoom_cfg.max_level      = val;
      CFG_IN_SPEED:       zoom_cfg.in_speed       = val[SPEED_W-1:0];
      CFG_OUT_SPEED:      zoom_cfg.out_speed      = val[SPEED_W-1:0];
      CFG_SMOOTH_ENABLE:  zoom_cfg.smooth_enable  = val[0];
      CFG_START_FRACTION: zoom_cfg.start_fraction = val[SF_W-1:0];
      CFG_RAMP_RATE:      zoom_cfg.ramp_rate      = val;
      default: ;
    endcase
  endtask

  task automatic load_config(input ezr_cfg_t c);
    wait_results_done();
    write_reg(CFG_MIN_LEVEL, c.min_level);
    write_reg(CFG_MAX_LEVEL, c.max_level);
    write_reg(CFG_IN_SPEED, CFG_DAT_W'(c.in_speed));
    write_reg(CFG_OUT_SPEED, CFG_DAT_W'(c.out_speed));
    write_reg(CFG_SMOOTH_ENABLE, CFG_DAT_W'(c.smooth_enable));
    write_reg(CFG_START_FRACTION, CFG_DAT_W'(c.start_fraction));
    write_reg(CFG_RAMP_RATE, c.ramp_rate);
    cfg_valid_i <= 1'b0;
    configs_loaded++;
  endtask

  function automatic ezr_cfg_t make_config(
    input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi,
    input logic [SPEED_W-1:0] spd_in, input logic [SPEED_W-1:0] spd_out,
    input logic smooth, input logic [SF_W-1:0] sf, input logic [LEVEL_W-1:0] ramp);
    ezr_cfg_t c;
    c.min_level      = lo;
    c.max_level      = hi;
    c.in_speed       = spd_in;
    c.out_speed      = spd_out;
    c.smooth_enable  = smooth;
    c.start_fraction = sf;
    c.ramp_rate      = ramp;
    return c;
  endfunction

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return SPEED_W'($urandom_range(16'h3000, 16'h400));
    endcase
  endfunction

  function automatic ezr_cfg_t pick_config();
    ezr_cfg_t c;
    case ($urandom_range(7))
      0: c.min_level = '0;
      1: c.min_level = LEVEL_MAX;
      default: c.min_level = LEVEL_W'($urandom_range(24'h20000, 24'h4000));
    endcase
    case ($urandom_range(7))
      0: c.max_level = LEVEL_MAX;
      1: c.max_level = '0;
      default: c.max_level = LEVEL_W'($urandom_range(24'h800000, 24'h40000));
    endcase
    c.in_speed      = pick_speed();
    c.out_speed     = pick_speed();
    c.smooth_enable = ($urandom_range(3) != 0);
    case ($urandom_range(7))
      0: c.start_fraction = '0;
      1: c.start_fraction = SF_ONE;
      2: c.start_fraction = '1;
      default: c.start_fraction = SF_W'($urandom_range(65535));
    endcase
    case ($urandom_range(7))
      0: c.ramp_rate = '0;
      1: c.ramp_rate = LEVEL_MAX;
      2: c.ramp_rate = LEVEL_W'($urandom_range(16, 1));
      default: c.ramp_rate = LEVEL_W'($urandom_range(24'h40000, 24'h1000));
    endcase
    return c;
  endfunction

  // key runs keep one direction held for a while so the ease-in ramp gets exercised
  function automatic ezr_in_t next_request();
    ezr_in_t     r;
    int unsigned roll;
    r.mode          = MODE_TICK;
    r.zoom_in_held  = 1'($urandom_range(1));
    r.zoom_out_held = 1'($urandom_range(1));
    r.dt            = DT_W'($urandom);
    r.new_level     = LEVEL_W'($urandom);
    if (run_left == 0) begin
      roll     = $urandom_range(99);
      run_dir  = (roll < 60) ? DIR_IN : (roll < 85) ? DIR_OUT : DIR_NONE;
      run_left = $urandom_range(40, 1);
    end
    run_left--;
    roll = $urandom_range(99);
    if (roll < 78) begin
      case (run_dir)
        DIR_IN:  {r.zoom_in_held, r.zoom_out_held} = 2'b10;
        DIR_OUT: {r.zoom_in_held, r.zoom_out_held} = 2'b01;
        default: {r.zoom_in_held, r.zoom_out_held} = {2{r.zoom_in_held}};
      endcase
      case ($urandom_range(15))
        0: r.dt = '0;
        1: r.dt = '1;
        2, 3, 4, 5: r.dt = DT_W'($urandom_range(16'h800));
        default: ;
      endcase
    end else if (roll < 87) begin
      r.mode = MODE_SET;
      if ($urandom_range(3) == 0) r.new_level = LEVEL_W'($urandom_range(24'h80000));
    end else if (roll < 94) begin
      r.mode = MODE_RESTART;
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  task automatic test_basic_ops();
    send_op(MODE_TICK, 1'b1, 1'b1, 16'hFFFF, 24'h0);
    send_op(MODE_TICK, 1'b0, 1'b0, 16'h1234, 24'hFFFFFF);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'h0000, 24'h0);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'h4000, 24'h0);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'hFFFF, 24'h0);
    send_op(MODE_TICK, 1'b0, 1'b1, 16'hFFFF, 24'h0);
    send_op(MODE_SET, 1'b0, 1'b0, 16'h0, 24'h000000);
    send_op(MODE_SET, 1'b1, 1'b1, 16'hFFFF, 24'hFFFFFF);
    send_op(MODE_SET, 1'b0, 1'b1, 16'h0, 24'h030000);
    send_op(MODE_UNUSED, 1'b1, 1'b0, 16'hFFFF, 24'hFFFFFF);
    send_op(MODE_RESTART, 1'b1, 1'b0, 16'hFFFF, 24'hFFFFFF);
  endtask

  task automatic test_limit_cases();
    // full range, top speeds: saturate high, fall to zero, stay at zero
    load_config(make_config('0, LEVEL_MAX, '1, '1, 1'b0, SF_ONE, '0));
    send_op(MODE_SET, 1'b0, 1'b0, 16'h0, 24'h010000);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'hFFFF, 24'h0);
    send_op(MODE_TICK, 1'b0, 1'b1, 16'hFFFF, 24'h0);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'hFFFF, 24'h0);
    // min above max
    load_config(make_config(24'h800000, 24'h010000, 16'h1000, 16'h1000, 1'b0, SF_ONE, '0));
    send_op(MODE_SET, 1'b0, 1'b0, 16'h0, 24'h400000);
    send_op(MODE_TICK, 1'b0, 1'b1, 16'h8000, 24'h0);
    send_op(MODE_RESTART, 1'b0, 1'b0, 16'h0, 24'h0);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'h0100, 24'h0);
    // start fraction above one disables ease-in
    load_config(make_config(24'h001000, LEVEL_MAX, 16'h1000, 16'h1000, 1'b1, '1, 24'h010000));
    send_op(MODE_RESTART, 1'b0, 1'b0, 16'h0, 24'h0);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'h8000, 24'h0);
    send_op(MODE_TICK, 1'b1, 1'b0, 16'h8000, 24'h0);
    // ease-in from zero speed
    load_config(make_config(24'h001000, LEVEL_MAX, 16'h2000, 16'h1000, 1'b1, '0, 24'h008000));
    send_op(MODE_RESTART, 1'b0, 1'b0, 16'h0, 24'h0);
    repeat (4) send_op(MODE_TICK, 1'b1, 1'b0, 16'h4000, 24'h0);
    send_op(MODE_TICK, 1'b0, 1'b1, 16'h4000, 24'h0);
  endtask

  // a long in-hold drives the held time into saturation; set level keeps the held time
  task automatic test_held_time_saturation();
    int i;
    load_config(make_config('0, LEVEL_MAX, '1, 16'h1000, 1'b1, '0, 24'h000001));
    send_op(MODE_RESTART, 1'b0, 1'b0, 16'h0, 24'h0);
    for (i = 0; i < 340; i++) begin
      if (i % 8 == 0) send_op(MODE_SET, 1'($urandom), 1'($urandom), DT_W'($urandom),
                              24'h010000);
      else send_op(MODE_TICK, 1'b1, 1'b0, DT_W'($urandom_range(16'hFFFF, 16'hF000)),
                   LEVEL_W'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned sent;
    int unsigned chunk;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      load_config(pick_config());
      chunk = $urandom_range(150, 90);
      repeat (chunk) send_request(next_request());
      sent += chunk;
    end
  endtask

  task automatic test_backpressure();
    hold_until = stall_cycle + HOLD_CYCLES;
    repeat (30) send_request(next_request());
    wait_results_done();
    repeat (10) send_request(next_request());
  endtask

  initial begin
    zoom_cfg  = make_config(24'h010000, 24'h080000, 16'h1000, 16'h1000, 1'b0, SF_ONE, '0);
    level_q   = LEVEL_RESET;
    held_time = '0;
    cur_dir   = DIR_NONE;
    send_idle_pct = 11;
    recv_idle_pct = 83;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_limit_cases();
    test_random_traffic(290, 11, 83);
    test_held_time_saturation();
    test_random_traffic(290, 83, 11);
    test_random_traffic(290, 0, 0);
    test_backpressure();

    wait_results_done();
    repeat (480) @(posedge clk_i);
    $display("covered %0d requests and %0d results over %0d register settings,",
             requests_sent, results_checked, configs_loaded);
    $display("with directed limits, held-time saturation, random idling and a long stall");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ezr_pkg.sv
sv/ezr_serial_mul.sv
sv/ezr_serial_div.sv
sv/ezr_seq.sv
sv/exponential_zoom_ramp_integrator_top.sv
dv/tb.sv
